@@ hdl/base64_stream_codec_top_macros.svh @@
// ----------------------------------------------------------------------------
// Base64 stream codec assertion macros
// Concurrent checks used by the codec top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_TOP_MACROS_SVH
`define BASE64_STREAM_CODEC_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define B64SC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64sc check failed");

// next-cycle implication, held off during reset
`define B64SC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64sc check failed");

`endif

@@ hdl/b64sc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and character maps of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int LINE_CHARS = 64;
  localparam int JOB_BEATS  = 6;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [JOB_BEATS-1:0][7:0] data;
    logic [2:0]                cnt;
    logic                      last;
    logic                      err;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } chan_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic sextet_t b64_sextet(input logic [7:0] c);
    sextet_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.ok  = 1'b1;
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.ok  = 1'b1;
      r.val = 6'd63;
    end
    return r;
  endfunction

endpackage

@@ hdl/b64sc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input beats, keeps the group state and builds at most one output
// job per beat (encoded characters with line breaks, or decoded bytes).
// ----------------------------------------------------------------------------
module b64sc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode_we,
  input  logic            mode_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            last_item,
  input  logic            q_full,
  output b64sc_pkg::chan_t push
);

  logic        mode;
  logic [23:0] group_buffer;
  logic [1:0]  group_fill;
  logic [7:0]  line_count;
  logic [1:0]  pad_count;
  logic        error_seen;

  logic        accept;

  // encode path
  logic [23:0] enc_buf;
  logic [1:0]  enc_fill;
  logic [7:0]  sym [4];
  logic [3:0]  sym_en;
  logic [3:0]  sym_chk;
  logic [b64sc_pkg::JOB_BEATS-1:0][7:0] e_data;
  logic [2:0]  e_n;
  logic [7:0]  e_lc;

  // decode path
  b64sc_pkg::sextet_t d_sx;
  logic        d_is_nl;
  logic        d_is_pad;
  logic [5:0]  d_v;
  logic [1:0]  d_pad_n;
  logic        d_err_n;
  logic        d_grp;
  logic [23:0] d_all;
  logic [2:0]  d_cnt;
  logic        d_err_end;

  b64sc_pkg::job_t job;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  assign enc_buf  = {group_buffer[15:0], in_byte};
  assign enc_fill = group_fill + 2'd1;

  always_comb begin
    sym[0] = b64sc_pkg::b64_char(enc_buf[23:18]);
    sym[1] = b64sc_pkg::b64_char(enc_buf[17:12]);
    sym[2] = b64sc_pkg::b64_char(enc_buf[11:6]);
    sym[3] = b64sc_pkg::b64_char(enc_buf[5:0]);
    sym_en  = 4'b1111;
    sym_chk = 4'b1111;
    if (enc_fill == 2'd3) begin
      sym_en = 4'b1111;
    end else if (last_item && enc_fill == 2'd1) begin
      sym[0]  = b64sc_pkg::b64_char(enc_buf[7:2]);
      sym[1]  = b64sc_pkg::b64_char({enc_buf[1:0], 4'b0000});
      sym[2]  = b64sc_pkg::CHAR_PAD;
      sym[3]  = b64sc_pkg::CHAR_PAD;
      sym_chk = 4'b0111;
    end else if (last_item && enc_fill == 2'd2) begin
      sym[0]  = b64sc_pkg::b64_char(enc_buf[15:10]);
      sym[1]  = b64sc_pkg::b64_char({enc_buf[9:8], enc_buf[7:4]});
      sym[2]  = b64sc_pkg::b64_char({enc_buf[3:0], 2'b00});
      sym[3]  = b64sc_pkg::CHAR_PAD;
      sym_chk = 4'b0111;
    end else begin
      sym_en = 4'b0000;
    end
  end

  always_comb begin
    e_data = '0;
    e_n    = 3'd0;
    e_lc   = line_count;
    for (int i = 0; i < 4; i++) begin
      if (sym_en[i]) begin
        e_data[e_n] = sym[i];
        e_n         = e_n + 3'd1;
        e_lc        = e_lc + 8'd1;
        if (sym_chk[i] && e_lc >= 8'(b64sc_pkg::LINE_CHARS)) begin
          e_data[e_n] = b64sc_pkg::CHAR_NL;
          e_n         = e_n + 3'd1;
          e_lc        = 8'd0;
        end
      end
    end
    if (last_item) begin
      e_data[e_n] = b64sc_pkg::CHAR_NL;
      e_n         = e_n + 3'd1;
    end
  end

  assign d_sx     = b64sc_pkg::b64_sextet(in_byte);
  assign d_is_nl  = in_byte == b64sc_pkg::CHAR_NL;
  assign d_is_pad = in_byte == b64sc_pkg::CHAR_PAD;
  assign d_v      = (d_is_pad || !d_sx.ok) ? 6'd0 : d_sx.val;
  assign d_pad_n  = (d_is_pad && pad_count != 2'd3) ? pad_count + 2'd1 : pad_count;
  assign d_err_n  = error_seen
                  | (d_is_pad && pad_count >= 2'd2)
                  | (!d_is_pad && (!d_sx.ok || pad_count != 2'd0));
  assign d_grp    = !d_is_nl && group_fill == 2'd3;
  assign d_all    = {group_buffer[17:0], d_v};
  assign d_cnt    = (d_pad_n >= 2'd2) ? 3'd1 : ((d_pad_n == 2'd1) ? 3'd2 : 3'd3);
  // a final newline is an error only if one was seen or the group is incomplete; any other final character is an error
  assign d_err_end = d_is_nl ? (error_seen | (group_fill != 2'd0)) : 1'b1;

  always_comb begin
    job = '0;
    if (mode == b64sc_pkg::MODE_ENCODE) begin
      job.data = e_data;
      job.cnt  = e_n;
      job.last = last_item;
    end else if (d_grp) begin
      job.data[0] = d_all[23:16];
      job.data[1] = d_all[15:8];
      job.data[2] = d_all[7:0];
      job.cnt     = d_cnt;
      job.last    = last_item;
      job.err     = last_item & d_err_n;
    end else if (last_item) begin
      job.cnt  = 3'd1;
      job.last = 1'b1;
      job.err  = d_err_end;
    end
  end

  assign push.valid = accept && job.cnt != 3'd0;
  assign push.job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= b64sc_pkg::MODE_ENCODE;
      group_buffer <= '0;
      group_fill   <= '0;
      line_count   <= '0;
      pad_count    <= '0;
      error_seen   <= 1'b0;
    end else if (mode_we) begin
      mode         <= mode_wdata;
      group_buffer <= '0;
      group_fill   <= '0;
      line_count   <= '0;
      pad_count    <= '0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      if (last_item) begin
        group_buffer <= '0;
        group_fill   <= '0;
        line_count   <= '0;
        pad_count    <= '0;
        error_seen   <= 1'b0;
      end else if (mode == b64sc_pkg::MODE_ENCODE) begin
        group_buffer <= (enc_fill == 2'd3) ? 24'd0 : enc_buf;
        group_fill   <= (enc_fill == 2'd3) ? 2'd0 : enc_fill;
        line_count   <= e_lc;
      end else if (!d_is_nl) begin
        pad_count    <= d_pad_n;
        error_seen   <= d_err_n;
        group_buffer <= d_grp ? 24'd0 : d_all;
        group_fill   <= d_grp ? 2'd0 : group_fill + 2'd1;
      end
    end
  end

endmodule

@@ hdl/b64sc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64sc_queue (
  input  logic             clk,
  input  logic             rst,
  input  b64sc_pkg::chan_t push,
  input  logic             pop,
  output b64sc_pkg::chan_t head,
  output logic             full
);

  b64sc_pkg::job_t                entry [b64sc_pkg::Q_DEPTH];
  logic [b64sc_pkg::Q_AW-1:0]     wptr;
  logic [b64sc_pkg::Q_AW-1:0]     rptr;
  logic [b64sc_pkg::Q_AW:0]       fill;

  assign full       = fill == (b64sc_pkg::Q_AW+1)'(b64sc_pkg::Q_DEPTH);
  assign head.valid = fill != '0;
  assign head.job   = entry[rptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[wptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push.valid) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push.valid && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push.valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hdl/b64sc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_back
// Walks the head job one beat per cycle into the output register, unless out_stall holds it.
// ----------------------------------------------------------------------------
module b64sc_back (
  input  logic             clk,
  input  logic             rst,
  input  b64sc_pkg::chan_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             last_result,
  output logic             format_error
);

  logic [2:0] idx;
  logic       load;
  logic       job_end;

  assign load    = head.valid && (!out_valid || !out_stall);
  assign job_end = idx == head.job.cnt - 3'd1;
  assign pop     = load && job_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= job_end ? 3'd0 : idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head.job.data[idx];
      last_result  <= job_end & head.job.last;
      format_error <= job_end & head.job.err;
    end
  end

endmodule

@@ hdl/base64_stream_codec_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Base64 encoder/decoder on a byte stream with an end-of-message mark.
//
//   channel | dir | handshake                    | fields
//   input   | in  | in_valid / in_stall          | in_byte, last_item
//   output  | out | out_valid / out_stall        | out_byte, last_result,
//           |     |                              | format_error
//   config  | in  | mode_we                      | mode_wdata
//
// The back end moves one output beat per cycle unless out_stall holds it; each
// input beat yields 0 to 6 output beats, so encode gives about four
// characters per three bytes and decode three bytes per four characters. The
// front takes a beat each cycle until the two-job queue fills. Reset is
// synchronous and selects encode mode with an empty message. out_stall holds
// the output register; in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_top_macros.svh"

module base64_stream_codec_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       mode_we,
  input  logic       mode_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       last_item,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_result,
  output logic       format_error
);

  b64sc_pkg::chan_t q_push;
  b64sc_pkg::chan_t q_head;
  logic             q_pop;
  logic             q_full;

  b64sc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .last_item  (last_item),
    .q_full     (q_full),
    .push       (q_push)
  );

  b64sc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .pop  (q_pop),
    .head (q_head),
    .full (q_full)
  );

  b64sc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_result  (last_result),
    .format_error (format_error)
  );

  `B64SC_ASSERT_NOW(a_err_on_last, out_valid && format_error, last_result)
  `B64SC_ASSERT_NOW(a_pop_has_job, q_pop, q_head.valid)
  `B64SC_ASSERT_NOW(a_job_size, q_push.valid, q_push.job.cnt != 3'd0 && q_push.job.cnt <= 3'd6)
  `B64SC_ASSERT_NEXT(a_push_lands, q_push.valid && !q_head.valid, q_head.valid)

endmodule
